@@ design/scaler_phase_setup_top_assert.svh @@
// assertion macros for the scaler phase set-up block
// used by scaler_phase_setup_top; clk and rst_n must be in scope
`ifndef SCALER_PHASE_SETUP_TOP_ASSERT_SVH
`define SCALER_PHASE_SETUP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scaler phase set-up check failed");
`define SPS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scaler phase set-up reset check failed");
`else
`define SPS_ASSERT(lbl, prop)
`define SPS_ASSERT_RST(lbl, prop)
`endif

`endif

@@ design/sps_pkg.sv @@
// package for the scaler phase set-up block: payload types and constants
// no dependencies
`timescale 1ns / 1ps
package sps_pkg;

  localparam int DIV_NUM_W       = 48;
  localparam int DIV_DEN_W       = 32;
  localparam int PHASE_FRAC_BITS = 4;
  localparam int STEP_EXTRA_BITS = 12;
  localparam int STEP_SHIFT      = STEP_EXTRA_BITS + PHASE_FRAC_BITS;
  localparam int UP_SHIFT        = 32;
  localparam int INIT_W          = 20;

  typedef struct packed {
    logic [31:0] src_width_q16;
    logic [31:0] src_height_q16;
    logic [15:0] dst_width;
    logic [15:0] dst_height;
    logic        rotated;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       h_upscale_q16;
    logic [31:0]       v_upscale_q16;
    logic              enhancer_on;
    logic [15:0]       in_width;
    logic [15:0]       in_height;
    logic [INIT_W-1:0] h_phase_init;
    logic [31:0]       h_phase_step;
    logic [INIT_W-1:0] v_phase_init;
    logic [31:0]       v_phase_step;
    logic              div_error;
  } out_item_t;

  typedef struct packed {
    logic        err;
    logic [15:0] in_w;
    logic [15:0] in_h;
  } side_t;

endpackage

@@ design/sps_chan_if.sv @@
// valid/ready channel carrying one payload struct per transaction
// payload type given by parameter, normally from sps_pkg
`timescale 1ns / 1ps
interface sps_chan_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/sps_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// depends on sps_pkg for default widths
`timescale 1ns / 1ps
module sps_div #(
  parameter int NUM_W = sps_pkg::DIV_NUM_W,
  parameter int DEN_W = sps_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  import sps_pkg::*;

  logic [DEN_W-1:0] rem_r [0:NUM_W];
  logic [NUM_W-1:0] dq_r  [0:NUM_W];
  logic [DEN_W-1:0] den_r [0:NUM_W];

  assign rem_r[0] = '0;
  assign dq_r[0]  = num;
  assign den_r[0] = den;

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[g], dq_r[g][NUM_W-1]};
      diff    = trial - {1'b0, den_r[g]};
      ge      = (trial >= {1'b0, den_r[g]});
      // remainder stays below the divisor, so it fits the divisor width
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= rem_nxt;
        dq_r[g+1]  <= {dq_r[g][NUM_W-2:0], ge};
        den_r[g+1] <= den_r[g];
      end
    end
  end

  assign quo = dq_r[NUM_W];

endmodule

@@ design/scaler_phase_setup_top.sv @@
// Scaler phase set-up. One transaction in gives one result out, through the
// pipelined dividers (one quotient bit per stage). A new transaction is taken
// in every cycle while the pipeline moves; the whole pipeline halts only while a
// finished result waits at the output. Zero divisors set div_error and zero the rest.
// depends on sps_pkg, sps_chan_if, sps_div and scaler_phase_setup_top_assert.svh
`timescale 1ns / 1ps
`include "scaler_phase_setup_top_assert.svh"
module scaler_phase_setup_top (
  input logic                             clk,
  input logic                             rst_n,
  sps_chan_if.sink                        in_if,
  sps_chan_if.source                      out_if
);
  import sps_pkg::*;

  localparam int LAT = DIV_NUM_W;

  logic             en;
  logic             valid_r [1:LAT];
  side_t            side_r  [0:LAT];
  logic [15:0]      iw;
  logic [15:0]      ih;
  logic [DIV_NUM_W-1:0] hup_q, vup_q, hd_q, vd_q;
  logic [INIT_W:0]  h_init_sum, v_init_sum;
  out_item_t        res;
  in_item_t         d;

  assign d  = in_if.data;
  // the whole pipeline moves unless a result sits unclaimed at the output
  assign en = !valid_r[LAT] || out_if.ready;
  assign in_if.ready = en;

  assign iw = d.rotated ? d.src_height_q16[31:16] : d.src_width_q16[31:16];
  assign ih = d.rotated ? d.src_width_q16[31:16]  : d.src_height_q16[31:16];

  assign side_r[0].err  = (d.src_width_q16 == '0) || (d.src_height_q16 == '0) ||
                          (d.dst_width == '0) || (d.dst_height == '0);
  assign side_r[0].in_w = iw;
  assign side_r[0].in_h = ih;

  for (genvar g = 1; g <= LAT; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= (g == 1) ? in_if.valid : valid_r[(g > 1) ? g - 1 : 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= side_r[g-1];
      end
    end
  end

  sps_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_hup (
    .clk(clk), .en(en),
    .num(DIV_NUM_W'(d.dst_width) << UP_SHIFT),
    .den(d.src_width_q16), .quo(hup_q));

  sps_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_vup (
    .clk(clk), .en(en),
    .num(DIV_NUM_W'(d.dst_height) << UP_SHIFT),
    .den(d.src_height_q16), .quo(vup_q));

  sps_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_hd (
    .clk(clk), .en(en),
    .num(DIV_NUM_W'(iw) << STEP_SHIFT),
    .den(DIV_DEN_W'(d.dst_width)), .quo(hd_q));

  sps_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_vd (
    .clk(clk), .en(en),
    .num(DIV_NUM_W'(ih) << STEP_SHIFT),
    .den(DIV_DEN_W'(d.dst_height)), .quo(vd_q));

  // initial phase is half the step, rounded, with the extra fraction bits dropped
  assign h_init_sum = {1'b0, hd_q[31:STEP_EXTRA_BITS]} + (INIT_W+1)'(1);
  assign v_init_sum = {1'b0, vd_q[31:STEP_EXTRA_BITS]} + (INIT_W+1)'(1);

  always_comb begin
    res = '0;
    res.div_error = side_r[LAT].err;
    if (!side_r[LAT].err) begin
      res.h_upscale_q16 = hup_q[31:0];
      res.v_upscale_q16 = vup_q[31:0];
      res.enhancer_on   = (hup_q[31:17] != '0) || (vup_q[31:17] != '0);
      res.in_width      = side_r[LAT].in_w;
      res.in_height     = side_r[LAT].in_h;
      res.h_phase_init  = h_init_sum[INIT_W:1];
      res.h_phase_step  = hd_q[31:0];
      res.v_phase_init  = v_init_sum[INIT_W:1];
      res.v_phase_step  = vd_q[31:0];
    end
  end

  assign out_if.valid = valid_r[LAT];
  assign out_if.data  = res;

  `SPS_ASSERT(a_ready_only_on_hold, !in_if.ready |-> out_if.valid && !out_if.ready)
  `SPS_ASSERT(a_err_zeroes, out_if.valid && res.div_error |-> res.h_phase_step == '0)
  `SPS_ASSERT(a_err_no_enh, out_if.valid && res.div_error |-> !res.enhancer_on)
  `SPS_ASSERT(a_enh_needs_big, res.enhancer_on |-> res.h_upscale_q16[31:17] != '0 || res.v_upscale_q16[31:17] != '0)
  `SPS_ASSERT_RST(a_reset_empty, !$past(rst_n) |-> !out_if.valid)

endmodule

@@ bench/scaler_phase_setup_top_test.sv @@
// testbench for scaler_phase_setup_top: directed corner cases then random plane set-ups
// depends on sps_pkg, sps_chan_if and the block itself; checks every result against a predictor
`timescale 1ns / 1ps
module scaler_phase_setup_top_test;
  import sps_pkg::*;

  localparam int LATENCY     = 48;
  localparam int IDLE_LIMIT  = 4000;

  logic clk;
  logic rst_n;

  sps_chan_if #(.data_t(in_item_t))  req_ch ();
  sps_chan_if #(.data_t(out_item_t)) res_ch ();

  scaler_phase_setup_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch.sink),
    .out_if (res_ch.source)
  );

  out_item_t setup_expected[$];
  int        err_count;
  int        sent_count;
  int        got_count;
  int        idle_cycles;
  int        hold_off;
  bit        send_gaps;
  bit        recv_gaps;
  int        err_seen;
  int        rot_seen;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic out_item_t predict_setup(in_item_t r);
    out_item_t   o;
    logic [63:0] hup;
    logic [63:0] vup;
    logic [15:0] iw;
    logic [15:0] ih;
    logic [63:0] hi;
    logic [63:0] hs;
    logic [63:0] vi;
    logic [63:0] vs;
    o = '0;
    if (r.src_width_q16 == 0 || r.src_height_q16 == 0 || r.dst_width == 0 ||
        r.dst_height == 0) begin
      o.div_error = 1'b1;
      return o;
    end
    hup = ({32'd0, r.dst_width, 16'd0} << 16) / {32'd0, r.src_width_q16};
    vup = ({32'd0, r.dst_height, 16'd0} << 16) / {32'd0, r.src_height_q16};
    o.h_upscale_q16 = hup[31:0];
    o.v_upscale_q16 = vup[31:0];
    o.enhancer_on = (hup[31:16] >= 2) || (vup[31:16] >= 2);
    iw = r.rotated ? r.src_height_q16[31:16] : r.src_width_q16[31:16];
    ih = r.rotated ? r.src_width_q16[31:16] : r.src_height_q16[31:16];
    o.in_width  = iw;
    o.in_height = ih;
    hi = ((({48'd0, iw} << 4) / {48'd0, r.dst_width}) + 64'd1) / 64'd2;
    hs = ({48'd0, iw} << 16) / {48'd0, r.dst_width};
    vi = ((({48'd0, ih} << 4) / {48'd0, r.dst_height}) + 64'd1) / 64'd2;
    vs = ({48'd0, ih} << 16) / {48'd0, r.dst_height};
    o.h_phase_init = hi[19:0];
    o.h_phase_step = hs[31:0];
    o.v_phase_init = vi[19:0];
    o.v_phase_step = vs[31:0];
    return o;
  endfunction

  // called at a falling edge; valid stays high into the next call when no gap is drawn
  task automatic send_setup(in_item_t r);
    int gap;
    gap = send_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    setup_expected.push_back(predict_setup(r));
    sent_count++;
    if (r.rotated) rot_seen++;
    @(negedge clk);
  endtask

  // result side: random stalls, a long hold-off when asked
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        stall = recv_gaps ? $urandom_range(0, 18) : 0;
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
          @(negedge clk);
        end
        res_ch.ready <= 1'b1;
        @(posedge clk);
        while (!res_ch.valid) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    out_item_t a;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      a = res_ch.data;
      got_count++;
      if (setup_expected.size() == 0) begin
        $error("result with no request outstanding");
        err_count++;
      end else begin
        e = setup_expected.pop_front();
        if (a.div_error) err_seen++;
        if (a.h_upscale_q16 !== e.h_upscale_q16) begin
          $error("h_upscale_q16 exp %h got %h", e.h_upscale_q16, a.h_upscale_q16);
          err_count++;
        end
        if (a.v_upscale_q16 !== e.v_upscale_q16) begin
          $error("v_upscale_q16 exp %h got %h", e.v_upscale_q16, a.v_upscale_q16);
          err_count++;
        end
        if (a.enhancer_on !== e.enhancer_on) begin
          $error("enhancer_on exp %b got %b", e.enhancer_on, a.enhancer_on);
          err_count++;
        end
        if (a.in_width !== e.in_width) begin
          $error("in_width exp %h got %h", e.in_width, a.in_width);
          err_count++;
        end
        if (a.in_height !== e.in_height) begin
          $error("in_height exp %h got %h", e.in_height, a.in_height);
          err_count++;
        end
        if (a.h_phase_init !== e.h_phase_init) begin
          $error("h_phase_init exp %h got %h", e.h_phase_init, a.h_phase_init);
          err_count++;
        end
        if (a.h_phase_step !== e.h_phase_step) begin
          $error("h_phase_step exp %h got %h", e.h_phase_step, a.h_phase_step);
          err_count++;
        end
        if (a.v_phase_init !== e.v_phase_init) begin
          $error("v_phase_init exp %h got %h", e.v_phase_init, a.v_phase_init);
          err_count++;
        end
        if (a.v_phase_step !== e.v_phase_step) begin
          $error("v_phase_step exp %h got %h", e.v_phase_step, a.v_phase_step);
          err_count++;
        end
        if (a.div_error !== e.div_error) begin
          $error("div_error exp %b got %b", e.div_error, a.div_error);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("** scaler_phase_setup_top: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t make_setup(logic [31:0] sw, logic [31:0] sh,
                                          logic [15:0] dw, logic [15:0] dh, logic rot);
    in_item_t r;
    r.src_width_q16  = sw;
    r.src_height_q16 = sh;
    r.dst_width      = dw;
    r.dst_height     = dh;
    r.rotated        = rot;
    return r;
  endfunction

  task automatic test_corners();
    send_setup(make_setup(32'd0, 32'h0010_0000, 16'd64, 16'd64, 1'b0));
    send_setup(make_setup(32'h0010_0000, 32'd0, 16'd64, 16'd64, 1'b0));
    send_setup(make_setup(32'h0010_0000, 32'h0010_0000, 16'd0, 16'd64, 1'b1));
    send_setup(make_setup(32'h0010_0000, 32'h0010_0000, 16'd64, 16'd0, 1'b0));
    send_setup(make_setup(32'd0, 32'd0, 16'd0, 16'd0, 1'b1));
    send_setup(make_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_setup(make_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // tiny source: quotient wider than 32 bits gets cut
    send_setup(make_setup(32'd1, 32'd1, 16'hFFFF, 16'd1, 1'b0));
    send_setup(make_setup(32'd1, 32'd3, 16'd2, 16'hFFFF, 1'b1));
    send_setup(make_setup(32'h0001_0000, 32'h0001_0000, 16'd1, 16'd1, 1'b0));
    send_setup(make_setup(32'h0001_0000, 32'h0001_0000, 16'd2, 16'd1, 1'b0));
    send_setup(make_setup(32'h0001_0000, 32'h0001_0000, 16'd1, 16'd2, 1'b1));
    send_setup(make_setup(32'h0780_0000, 32'h0438_0000, 16'd1280, 16'd720, 1'b0));
    send_setup(make_setup(32'h0780_0000, 32'h0438_0000, 16'd720, 16'd1280, 1'b1));
    send_setup(make_setup(32'h0000_8000, 32'h0002_0000, 16'd1, 16'd1, 1'b0));
    send_setup(make_setup(32'h0000_FFFF, 32'h0000_FFFF, 16'd1, 16'd1, 1'b1));
    send_setup(make_setup(32'hFFFF_0000, 32'h0001_0000, 16'd1, 16'hFFFF, 1'b0));
    send_setup(make_setup(32'h1234_5678, 32'h8765_4321, 16'h5555, 16'hAAAA, 1'b1));
  endtask

  function automatic logic [31:0] rand_src();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 32'h0000_FFFF);
      1: return $urandom_range(32'h0001_0000, 32'h1000_0000);
      2: return $urandom();
      default: return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 32'h0FFF_FFFF);
    endcase
  endfunction

  function automatic logic [15:0] rand_dst();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 16));
      1: return 16'($urandom_range(1, 4096));
      2: return 16'($urandom());
      default: return $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic test_random(int n, bit gaps_in, bit gaps_out);
    send_gaps = gaps_in;
    recv_gaps = gaps_out;
    repeat (n) send_setup(make_setup(rand_src(), rand_src(), rand_dst(), rand_dst(),
                                     1'($urandom_range(0, 1))));
  endtask

  // receiver held off for a long stretch while requests keep arriving
  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_off  = 300;
    repeat (150) send_setup(make_setup($urandom(), $urandom(), 16'($urandom()),
                                       16'($urandom()), 1'($urandom_range(0, 1))));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (setup_expected.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    err_count = 0;
    sent_count = 0;
    got_count = 0;
    err_seen = 0;
    rot_seen = 0;
    hold_off = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corners();
    test_random(400, 1'b1, 1'b1);
    test_random(300, 1'b0, 1'b0);
    test_backpressure();
    test_random(300, 1'b1, 1'b0);
    test_random(300, 1'b0, 1'b1);
    drain();

    $display("sent %0d set-ups (%0d rotated), checked %0d results, %0d zero-divisor cases",
             sent_count, rot_seen, got_count, err_seen);
    if (err_count == 0 && setup_expected.size() == 0) begin
      $display("** scaler_phase_setup_top: PASSED **");
    end else begin
      if (setup_expected.size() != 0)
        $error("%0d results never arrived", setup_expected.size());
      $display("** scaler_phase_setup_top: FAILED **");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/sps_pkg.sv
design/sps_chan_if.sv
design/sps_div.sv
design/scaler_phase_setup_top.sv
bench/scaler_phase_setup_top_test.sv
